>>> rtl/crc_framed_memory_write_sequencer_assert.svh
// Assertion macros shared by the checker files of the write sequencer.
// Depends on nothing; the including module supplies clk and rst.
`ifndef CRC_FRAMED_MEMORY_WRITE_SEQUENCER_ASSERT_SVH
`define CRC_FRAMED_MEMORY_WRITE_SEQUENCER_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define CFMWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define CFMWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, reset included.
`define CFMWS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cfmws_pkg.sv
// Package of the framed memory write sequencer: request and frame types,
// register numbers, frame step codes and the CRC-8 helper. No dependencies.
package cfmws_pkg;

  localparam int MAX_BYTES = 32;
  localparam int COUNT_W   = 6;
  localparam int JOB_DEPTH = 2;

  localparam logic [7:0] REG_SUB_LO   = 8'h3E;
  localparam logic [7:0] REG_SUB_HI   = 8'h3F;
  localparam logic [7:0] REG_BUF_BASE = 8'h40;
  localparam logic [7:0] REG_BUF_SUM  = 8'h60;
  localparam logic [7:0] REG_BUF_LEN  = 8'h61;
  localparam logic [7:0] WRITE_FLAG   = 8'h80;
  localparam logic [15:0] SUB_ENTER   = 16'h0090;
  localparam logic [15:0] SUB_EXIT    = 16'h0092;
  localparam logic [7:0] LEN_EXTRA    = 8'd4;
  localparam logic [7:0] CRC_POLY     = 8'h07;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] address;
    logic        last_byte;
    logic        config_update;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_command;
    logic [7:0] frame_value;
    logic [7:0] frame_crc;
    logic       status;
    logic       last_frame;
  } frame_t;

  // Frames of one request, in the order they leave.
  typedef enum logic [3:0] {
    STEP_ENTER_LO,
    STEP_ENTER_HI,
    STEP_ADDR_LO,
    STEP_ADDR_HI,
    STEP_BODY,
    STEP_SUM,
    STEP_LEN,
    STEP_EXIT_LO,
    STEP_EXIT_HI
  } step_t;

  localparam int NUM_STEPS = 9;

  typedef logic [NUM_STEPS-1:0] step_mask_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    step_mask_t         steps;
    logic [15:0]        address;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] index;
    logic               drop;
    logic [7:0]         sum_value;
    logic [7:0]         len_value;
  } job_t;

  typedef logic [15:0][7:0] crc_cols_t;

  // One byte through the CRC register, initial value given.
  function automatic logic [7:0] crc8_byte(input logic [7:0] start);
    logic [7:0] c;
    c = start;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // CRC of a two-byte message is linear in its bits: one column per bit.
  // Columns 0..7 belong to the second byte, 8..15 to the first.
  function automatic crc_cols_t crc_cols();
    crc_cols_t cols;
    for (int i = 0; i < 8; i++) begin
      cols[i]     = crc8_byte(8'(1 << i));
      cols[i + 8] = crc8_byte(crc8_byte(8'(1 << i)));
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_cols();

  function automatic logic [7:0] crc8_pair(input logic [7:0] first_byte,
                                           input logic [7:0] second_byte);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (second_byte[i]) c = c ^ CRC_COLS[i];
      if (first_byte[i])  c = c ^ CRC_COLS[i + 8];
    end
    return c;
  endfunction

endpackage

>>> rtl/cfmws_queue.sv
// Short request queue between the front and the back of the sequencer.
// Depends on cfmws_pkg (job_t, JOB_DEPTH).
module cfmws_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  cfmws_pkg::job_t  wr_job,
  output logic             full,
  input  logic             rd_en,
  output cfmws_pkg::job_t  rd_job,
  output logic             empty
);

  localparam int PTR_W = (cfmws_pkg::JOB_DEPTH > 1) ? $clog2(cfmws_pkg::JOB_DEPTH) : 1;
  localparam int CNT_W = $clog2(cfmws_pkg::JOB_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(cfmws_pkg::JOB_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(cfmws_pkg::JOB_DEPTH);

  cfmws_pkg::job_t  slots [cfmws_pkg::JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full   = (count == CNT_FULL);
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/cfmws_front.sv
// Front of the sequencer: accepts input bytes, tracks the block state and
// classifies each request into a job for the queue. Depends on cfmws_pkg.
module cfmws_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  cfmws_pkg::item_t item,
  output cfmws_pkg::job_t  job
);

  localparam logic [cfmws_pkg::COUNT_W-1:0] COUNT_MAX =
    cfmws_pkg::COUNT_W'(cfmws_pkg::MAX_BYTES);

  logic                            in_block;
  logic [cfmws_pkg::COUNT_W-1:0]   byte_count;
  logic [7:0]                      running_sum;
  logic                            wrap_mode;
  logic                            overflowed;

  logic                            first;
  logic [cfmws_pkg::COUNT_W-1:0]   cur_count;
  logic [7:0]                      cur_sum;
  logic                            cur_wrap;
  logic                            cur_ovf;
  logic                            drop;
  logic [cfmws_pkg::COUNT_W-1:0]   count_after;
  logic [7:0]                      sum_after;
  logic                            ovf_after;
  logic                            tail;

  always_comb begin
    first     = !in_block;
    cur_count = first ? '0 : byte_count;
    cur_sum   = first ? (item.address[7:0] + item.address[15:8]) : running_sum;
    cur_wrap  = first ? item.config_update : wrap_mode;
    cur_ovf   = first ? 1'b0 : overflowed;

    drop        = (cur_count >= COUNT_MAX);
    count_after = drop ? cur_count : cur_count + 1'b1;
    sum_after   = drop ? cur_sum : cur_sum + item.data_byte;
    ovf_after   = cur_ovf || drop;
    tail        = item.last_byte && !ovf_after;

    job.steps                          = '0;
    job.steps[cfmws_pkg::STEP_ENTER_LO] = first && cur_wrap;
    job.steps[cfmws_pkg::STEP_ENTER_HI] = first && cur_wrap;
    job.steps[cfmws_pkg::STEP_ADDR_LO]  = first;
    job.steps[cfmws_pkg::STEP_ADDR_HI]  = first;
    job.steps[cfmws_pkg::STEP_BODY]     = 1'b1;
    job.steps[cfmws_pkg::STEP_SUM]      = tail;
    job.steps[cfmws_pkg::STEP_LEN]      = tail;
    job.steps[cfmws_pkg::STEP_EXIT_LO]  = item.last_byte && cur_wrap;
    job.steps[cfmws_pkg::STEP_EXIT_HI]  = item.last_byte && cur_wrap;

    job.address   = item.address;
    job.data_byte = item.data_byte;
    job.index     = cur_count;
    job.drop      = drop;
    job.sum_value = ~sum_after;
    job.len_value = 8'(count_after) + cfmws_pkg::LEN_EXTRA;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_block    <= 1'b0;
      byte_count  <= '0;
      running_sum <= '0;
      wrap_mode   <= 1'b0;
      overflowed  <= 1'b0;
    end else if (accept) begin
      in_block    <= !item.last_byte;
      byte_count  <= item.last_byte ? '0 : count_after;
      running_sum <= sum_after;
      wrap_mode   <= cur_wrap;
      overflowed  <= item.last_byte ? 1'b0 : ovf_after;
    end
  end

endmodule

>>> rtl/cfmws_back.sv
// Back of the sequencer: walks the frames of the queue head, one per cycle
// while the output register is free or popped, builds command, value and
// CRC, and holds the output frame register. Depends on cfmws_pkg.
module cfmws_back (
  input  logic              clk,
  input  logic              rst,
  input  cfmws_pkg::job_t   head,
  input  logic              head_empty,
  output logic              head_pop,
  output cfmws_pkg::frame_t frame,
  output logic              empty,
  input  logic              pop
);

  cfmws_pkg::step_mask_t done;
  cfmws_pkg::step_mask_t done_next;
  logic                  frame_valid;

  cfmws_pkg::step_mask_t pending;
  cfmws_pkg::step_mask_t sel_bit;
  cfmws_pkg::step_t      sel;
  logic                  load;
  logic                  emit;
  logic                  final_step;
  logic [7:0]            cmd;
  logic [7:0]            value;
  logic                  status;
  cfmws_pkg::frame_t     frame_next;

  // Pick the earliest step still to send for the head request.
  always_comb begin
    pending = head.steps & ~done;
    sel     = cfmws_pkg::STEP_BODY;
    for (int i = cfmws_pkg::NUM_STEPS - 1; i >= 0; i--) begin
      if (pending[i]) sel = cfmws_pkg::step_t'(4'(i));
    end
    sel_bit    = cfmws_pkg::step_mask_t'(1) << sel;
    final_step = ((pending & ~sel_bit) == '0);
  end

  always_comb begin
    status = cfmws_pkg::STATUS_OK;
    unique case (sel)
      cfmws_pkg::STEP_ENTER_LO: begin
        cmd   = cfmws_pkg::REG_SUB_LO;
        value = cfmws_pkg::SUB_ENTER[7:0];
      end
      cfmws_pkg::STEP_ENTER_HI: begin
        cmd   = cfmws_pkg::REG_SUB_HI;
        value = cfmws_pkg::SUB_ENTER[15:8];
      end
      cfmws_pkg::STEP_ADDR_LO: begin
        cmd   = cfmws_pkg::REG_SUB_LO;
        value = head.address[7:0];
      end
      cfmws_pkg::STEP_ADDR_HI: begin
        cmd   = cfmws_pkg::REG_SUB_HI;
        value = head.address[15:8];
      end
      cfmws_pkg::STEP_BODY: begin
        cmd   = cfmws_pkg::REG_BUF_BASE + 8'(head.index);
        value = head.data_byte;
      end
      cfmws_pkg::STEP_SUM: begin
        cmd   = cfmws_pkg::REG_BUF_SUM;
        value = head.sum_value;
      end
      cfmws_pkg::STEP_LEN: begin
        cmd   = cfmws_pkg::REG_BUF_LEN;
        value = head.len_value;
      end
      cfmws_pkg::STEP_EXIT_LO: begin
        cmd   = cfmws_pkg::REG_SUB_LO;
        value = cfmws_pkg::SUB_EXIT[7:0];
      end
      cfmws_pkg::STEP_EXIT_HI: begin
        cmd   = cfmws_pkg::REG_SUB_HI;
        value = cfmws_pkg::SUB_EXIT[15:8];
      end
      default: begin
        cmd   = '0;
        value = '0;
      end
    endcase

    cmd = cmd | cfmws_pkg::WRITE_FLAG;

    // A dropped byte leaves as an all-zero frame flagged in status.
    if (sel == cfmws_pkg::STEP_BODY && head.drop) begin
      cmd    = '0;
      value  = '0;
      status = cfmws_pkg::STATUS_DROPPED;
    end

    frame_next.frame_command = cmd;
    frame_next.frame_value   = value;
    frame_next.frame_crc     = cfmws_pkg::crc8_pair(cmd, value);
    frame_next.status        = status;
    frame_next.last_frame    = final_step;
  end

  // Load the output register when it is free or being taken this cycle.
  always_comb begin
    load      = !frame_valid || pop;
    emit      = load && !head_empty;
    head_pop  = emit && final_step;
    done_next = done;
    if (emit) begin
      done_next = final_step ? '0 : (done | sel_bit);
    end
  end

  assign empty = !frame_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= '0;
      frame_valid <= 1'b0;
    end else begin
      done <= done_next;
      if (load) begin
        frame_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame <= frame_next;
    end
  end

endmodule

>>> rtl/crc_framed_memory_write_sequencer.sv
// Top level of the CRC-framed data-memory write sequencer.
// Depends on cfmws_pkg, cfmws_front, cfmws_queue and cfmws_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | push / full          | item  : data_byte, address, last_byte,
//            |                      |         config_update
//   result   | empty / pop          | frame : frame_command, frame_value,
//            |                      |         frame_crc, status, last_frame
//
// Each input request yields one to nine frames; the back sends one frame per
// cycle while the output register is free or being popped. The front takes
// a request every cycle while the two-entry job queue has room, so a new
// byte is taken while older frames still leave. Reset (rst, synchronous)
// ends any open block, empties the queue and the output register. A stalled
// pop holds the output frame; a full queue holds off push.
module crc_framed_memory_write_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cfmws_pkg::item_t  item,
  output logic              empty,
  input  logic              pop,
  output cfmws_pkg::frame_t frame
);

  logic            accept;
  cfmws_pkg::job_t front_job;
  cfmws_pkg::job_t head_job;
  logic            head_empty;
  logic            head_pop;

  // Take a request whenever the queue can hold its job.
  assign accept = push && !full;

  // Classify the request and advance the block state.
  cfmws_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .job    (front_job)
  );

  // Decouple classification from frame generation.
  cfmws_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_job (front_job),
    .full   (full),
    .rd_en  (head_pop),
    .rd_job (head_job),
    .empty  (head_empty)
  );

  // Expand the head job into frames; drop it from the queue after its last.
  cfmws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_job),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .frame      (frame),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

>>> rtl/cfmws_checker.sv
// Port-level checker for the write sequencer, bound to the top level.
// Depends on cfmws_pkg and crc_framed_memory_write_sequencer_assert.svh.
`include "crc_framed_memory_write_sequencer_assert.svh"

module cfmws_checker (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input cfmws_pkg::frame_t frame
);

  logic shown_drop;
  logic shown_ok;
  logic zero_bytes;

  assign shown_drop = !empty && (frame.status == cfmws_pkg::STATUS_DROPPED);
  assign shown_ok   = !empty && (frame.status == cfmws_pkg::STATUS_OK);
  assign zero_bytes = (frame.frame_command == 8'h00) && (frame.frame_value == 8'h00) &&
                      (frame.frame_crc == 8'h00);

  `CFMWS_ASSERT_SAME(a_drop_zero, shown_drop, zero_bytes, "dropped frame carries nonzero bytes")

  `CFMWS_ASSERT_SAME(a_write_flag, shown_ok, frame.frame_command[7], "valid frame lacks write flag")

  `CFMWS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(frame), "waiting frame changed")

  `CFMWS_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, empty, "frame shown right after reset")

endmodule

bind crc_framed_memory_write_sequencer cfmws_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .frame (frame)
);

>>> sim/tb_crc_framed_memory_write_sequencer.sv
// Self-checking testbench of the CRC-framed data-memory write sequencer.
// Depends on cfmws_pkg and the RTL under rtl/; predicts frames on its own.
module tb_crc_framed_memory_write_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  // Least number of random requests after the directed table.
  localparam int RANDOM_ITEMS = 355;
  // Run limit: far above the slowest run (nine frames per request, each frame
  // waiting out a sparse pop, plus sender gaps).
  localparam int CYCLE_LIMIT = 500_000;
  // Quiet cycles at the end, to catch frames that nobody expects.
  localparam int TAIL_CYCLES = 30;

  // One table row: a request, how often it repeats (data byte counting up),
  // and, where the answer is obvious, the single frame it must produce.
  typedef struct {
    cfmws_pkg::item_t  req;
    int unsigned       reps;
    logic              has_fixed;
    cfmws_pkg::frame_t fixed_frame;
  } row_t;

  typedef enum logic [1:0] {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_PATTERN} pop_mode_t;

  localparam cfmws_pkg::frame_t NO_FRAME = '0;
  // A dropped byte that is the only result of its request.
  localparam cfmws_pkg::frame_t DROP_ALONE = '{frame_command: 8'h00, frame_value: 8'h00,
                                               frame_crc: 8'h00,
                                               status: cfmws_pkg::STATUS_DROPPED,
                                               last_frame: 1'b1};

  localparam int NUM_ROWS = 16;

  // Directed table: extremes, wrapped and plain blocks, ignored mid-block
  // fields, a full 32-byte block, and both ways an overflowed block ends.
  row_t stim_rows [NUM_ROWS] = '{
    // wrapped single-byte block, every field at its top: nine frames
    '{'{8'hFF, 16'hFFFF, 1'b1, 1'b1}, 1, 1'b0, NO_FRAME},
    // plain single-byte block, all zeros
    '{'{8'h00, 16'h0000, 1'b1, 1'b0}, 1, 1'b0, NO_FRAME},
    // three-byte wrapped block; address and mode change mid-block, ignored
    '{'{8'hA5, 16'h8001, 1'b0, 1'b1}, 1, 1'b0, NO_FRAME},
    '{'{8'h5A, 16'h1234, 1'b0, 1'b0}, 1, 1'b0, NO_FRAME},
    '{'{8'h3C, 16'hFFFF, 1'b1, 1'b1}, 1, 1'b0, NO_FRAME},
    // exactly full block: 32 bytes, length frame 36
    '{'{8'h01, 16'h00FF, 1'b0, 1'b0}, 1, 1'b0, NO_FRAME},
    '{'{8'h10, 16'hABCD, 1'b0, 1'b1}, 30, 1'b0, NO_FRAME},
    '{'{8'h7F, 16'h0000, 1'b1, 1'b0}, 1, 1'b0, NO_FRAME},
    // wrapped block running over: 32 written, two dropped, exit still sent
    '{'{8'h80, 16'hFF00, 1'b0, 1'b1}, 1, 1'b0, NO_FRAME},
    '{'{8'h20, 16'h0000, 1'b0, 1'b0}, 31, 1'b0, NO_FRAME},
    '{'{8'h77, 16'h5555, 1'b0, 1'b0}, 1, 1'b1, DROP_ALONE},
    '{'{8'h88, 16'hAAAA, 1'b1, 1'b1}, 1, 1'b0, NO_FRAME},
    // plain block whose closing byte is dropped: nothing but the drop
    '{'{8'hC3, 16'h7FFF, 1'b0, 1'b0}, 1, 1'b0, NO_FRAME},
    '{'{8'h40, 16'h0001, 1'b0, 1'b1}, 31, 1'b0, NO_FRAME},
    '{'{8'hE7, 16'h0000, 1'b1, 1'b0}, 1, 1'b1, DROP_ALONE},
    // a fresh block must start clean after the overflow
    '{'{8'h55, 16'h1000, 1'b1, 1'b0}, 1, 1'b0, NO_FRAME}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              pop = 1'b0;
  cfmws_pkg::item_t  request_bus = '0;
  logic              full;
  logic              empty;
  cfmws_pkg::frame_t frame_bus;

  // Open-block state of the predictor.
  logic        blk_open = 1'b0;
  logic [15:0] blk_addr = '0;
  logic [5:0]  blk_count = '0;
  logic [7:0]  blk_sum = '0;
  logic        blk_wrapped = 1'b0;
  logic        blk_overflow = 1'b0;

  cfmws_pkg::frame_t step_frames[$];     // frames of the request being predicted
  cfmws_pkg::frame_t pending_frames[$];  // frames still owed by the block, oldest first
  cfmws_pkg::frame_t want_frame;
  int                fail_count = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  int                pop_age = 0;
  pop_mode_t         pop_mode = POP_ALWAYS;

  crc_framed_memory_write_sequencer uut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (request_bus),
    .empty (empty),
    .pop   (pop),
    .frame (frame_bus)
  );

  always #5 clk = ~clk;

  // CRC-8, polynomial 0x07, zero start: shift the 16 message bits in MSB first.
  function automatic logic [7:0] crc8_frame(input logic [7:0] cmd, input logic [7:0] val);
    logic [15:0] msg;
    logic [7:0]  c;
    msg = {cmd, val};
    c = 8'h00;
    for (int i = 15; i >= 0; i--) begin
      c = (c[7] ^ msg[i]) ? ({c[6:0], 1'b0} ^ cfmws_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  task automatic add_frame(input logic [7:0] reg_num, input logic [7:0] val);
    cfmws_pkg::frame_t f;
    f.frame_command = reg_num | cfmws_pkg::WRITE_FLAG;
    f.frame_value   = val;
    f.frame_crc     = crc8_frame(f.frame_command, val);
    f.status        = cfmws_pkg::STATUS_OK;
    f.last_frame    = 1'b0;
    step_frames.push_back(f);
  endtask

  // Subcommands and the block address go out as a low/high register pair.
  task automatic add_sub(input logic [15:0] word);
    add_frame(cfmws_pkg::REG_SUB_LO, word[7:0]);
    add_frame(cfmws_pkg::REG_SUB_HI, word[15:8]);
  endtask

  // Advance the block state by one request and collect its frames.
  task automatic predict_write(input cfmws_pkg::item_t it);
    cfmws_pkg::frame_t dropped;
    step_frames.delete();
    if (!blk_open) begin
      blk_open     = 1'b1;
      blk_addr     = it.address;
      blk_wrapped  = it.config_update;
      blk_count    = '0;
      blk_overflow = 1'b0;
      blk_sum      = it.address[7:0] + it.address[15:8];
      if (blk_wrapped) add_sub(cfmws_pkg::SUB_ENTER);
      add_sub(blk_addr);
    end
    if (blk_count >= cfmws_pkg::MAX_BYTES) begin
      dropped = '0;
      dropped.status = cfmws_pkg::STATUS_DROPPED;
      step_frames.push_back(dropped);
      blk_overflow = 1'b1;
    end else begin
      add_frame(cfmws_pkg::REG_BUF_BASE + 8'(blk_count), it.data_byte);
      blk_count = blk_count + 6'd1;
      blk_sum   = blk_sum + it.data_byte;
    end
    if (it.last_byte) begin
      // an overflowed block gets no checksum and no length
      if (!blk_overflow) begin
        add_frame(cfmws_pkg::REG_BUF_SUM, ~blk_sum);
        add_frame(cfmws_pkg::REG_BUF_LEN, 8'(blk_count) + cfmws_pkg::LEN_EXTRA);
      end
      if (blk_wrapped) add_sub(cfmws_pkg::SUB_EXIT);
      blk_open     = 1'b0;
      blk_count    = '0;
      blk_overflow = 1'b0;
    end
    step_frames[step_frames.size() - 1].last_frame = 1'b1;
  endtask

  // Offer one request, idling between bursts; return at the edge that takes it.
  task automatic send_request(input cfmws_pkg::item_t it, input logic has_fixed,
                              input cfmws_pkg::frame_t fixed_frame);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      // about one burst in four, drawn at random, is a long unbroken run
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    push        <= 1'b1;
    request_bus <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    // the request is taken at this edge: record what it owes
    predict_write(it);
    if (has_fixed) pending_frames.push_back(fixed_frame);
    else foreach (step_frames[i]) pending_frames.push_back(step_frames[i]);
  endtask

  // Hold off the sender until the block has delivered everything owed.
  task automatic drain_frames();
    push <= 1'b0;
    burst_left = 0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // Receiver: pop by one of four patterns, redrawn at random as pop_age advances.
  always @(posedge clk) begin
    if (pop_age % 48 == 0) pop_mode <= pop_mode_t'($urandom_range(0, 3));
    pop_age <= pop_age + 1;
    case (pop_mode)
      POP_ALWAYS:  pop <= 1'b1;
      POP_MOSTLY:  pop <= ($urandom_range(0, 3) != 0);
      POP_RARELY:  pop <= ($urandom_range(0, 3) == 0);
      default:     pop <= (pop_age % 5 < 2);
    endcase
  end

  // Compare each frame taken with the oldest one owed, field by field.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: cmd %02h value %02h crc %02h status %0b",
               frame_bus.frame_command, frame_bus.frame_value,
               frame_bus.frame_crc, frame_bus.status);
        fail_count++;
      end else begin
        want_frame = pending_frames.pop_front();
        if (frame_bus.frame_command !== want_frame.frame_command) begin
          $error("frame_command: expected %02h, got %02h",
                 want_frame.frame_command, frame_bus.frame_command);
          fail_count++;
        end
        if (frame_bus.frame_value !== want_frame.frame_value) begin
          $error("frame_value: expected %02h, got %02h",
                 want_frame.frame_value, frame_bus.frame_value);
          fail_count++;
        end
        if (frame_bus.frame_crc !== want_frame.frame_crc) begin
          $error("frame_crc: expected %02h, got %02h",
                 want_frame.frame_crc, frame_bus.frame_crc);
          fail_count++;
        end
        if (frame_bus.status !== want_frame.status) begin
          $error("status: expected %0b, got %0b", want_frame.status, frame_bus.status);
          fail_count++;
        end
        if (frame_bus.last_frame !== want_frame.last_frame) begin
          $error("last_frame: expected %0b, got %0b",
                 want_frame.last_frame, frame_bus.last_frame);
          fail_count++;
        end
      end
    end
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    cfmws_pkg::item_t r;
    int               random_sent;
    int               blk_len;
    int               pick;
    logic             wrap;
    logic [15:0]      first_addr;
    logic             drained_mid;

    random_sent = 0;
    drained_mid = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; repeated rows count the data byte up.
    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int k = 0; k < int'(stim_rows[i].reps); k++) begin
        r = stim_rows[i].req;
        r.data_byte = stim_rows[i].req.data_byte + 8'(k);
        send_request(r, stim_rows[i].has_fixed, stim_rows[i].fixed_frame);
      end
    end
    drain_frames();

    // Random blocks: mostly short, some full length, a few running over.
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      blk_len = $urandom_range(1, 6);
      else if (pick < 93) blk_len = $urandom_range(7, 32);
      else                blk_len = $urandom_range(33, 36);
      wrap = 1'($urandom);
      first_addr = 16'($urandom);
      for (int k = 0; k < blk_len; k++) begin
        r.data_byte = 8'($urandom);
        // mid-block address and mode are noise the block must ignore
        r.address       = (k == 0) ? first_addr : 16'($urandom);
        r.config_update = (k == 0) ? wrap : 1'($urandom);
        r.last_byte     = (k == blk_len - 1);
        send_request(r, 1'b0, NO_FRAME);
      end
      random_sent += blk_len;
      if (!drained_mid && random_sent >= RANDOM_ITEMS / 2) begin
        drain_frames();
        drained_mid = 1'b1;
      end
    end

    // Drain, then stay quiet long enough for any stray frame to show.
    drain_frames();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
